### rtl/core/sca_pkg.sv
// Shared types and constants of the size-class block allocator.
`timescale 1ns / 1ps
package sca_pkg;

   localparam int OFFSET_W = 16;
   localparam int SIZE_W   = 16;
   localparam int POOL_W   = 17;
   localparam int STATUS_W = 3;
   localparam int LINK_W   = 13;
   localparam int INDEX_W  = 12;

   localparam logic [15:0] HEADER_BYTES = 16'd8;
   localparam logic [16:0] POOL_RESET   = 17'd65536;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 3'd0,
      ST_ZERO    = 3'd1,
      ST_LARGE   = 3'd2,
      ST_NOSPACE = 3'd3,
      ST_NULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [INDEX_W-1:0] index;
   } link_type;

endpackage

### rtl/core/sca_ifs.sv
// Valid/ready channel interfaces of the allocator: request, response, csr write.
`timescale 1ns / 1ps
interface sca_req_if;
   import sca_pkg::*;
   logic                valid;
   logic                ready;
   logic                operation;
   logic [SIZE_W-1:0]   request_size;
   logic [OFFSET_W-1:0] data_offset;

   modport source (output valid, output operation, output request_size,
                   output data_offset, input ready);
   modport sink (input valid, input operation, input request_size,
                 input data_offset, output ready);
endinterface

interface sca_rsp_if;
   import sca_pkg::*;
   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] granted_offset;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output granted_offset, output status, input ready);
   modport sink (input valid, input granted_offset, input status, output ready);
endinterface

interface sca_csr_if;
   import sca_pkg::*;
   logic              valid;
   logic              ready;
   logic [POOL_W-1:0] pool_bytes;

   modport source (output valid, output pool_bytes, input ready);
   modport sink (input valid, input pool_bytes, output ready);
endinterface

### rtl/core/size_class_block_allocator.sv
// Top level of the size-class block allocator: sequencer, shared adder, header RAM.
`timescale 1ns / 1ps
// Serves one allocate or free request at a time. An allocate takes the smallest
// power-of-two class above size plus the 8-byte header, pops that class's free
// list or bump-allocates, and returns the block start plus 8; a free pushes the
// block back on the list of the class stored in its header. req_if.ready is high
// only while the sequencer is idle and reset is low. Each request passes the prep
// step, then reaches the reply step: a zero-size or null request at once, a
// too-large one after the class step, a free after reading its block's header and
// pushing the block if that holds a valid class, an allocate after popping or
// bump-allocating; a stalled response holds the sequencer in its reply step. The
// steps follow from the single shared adder, which forms size plus 8, offset minus
// 8 and cursor plus block size in turn, and from the registered read of the header
// RAM ahead of its write back. The header RAM needs no clearing after reset. csr_if
// is ready whenever reset is low; write it only while idle.
module size_class_block_allocator #(
   parameter int BUFFER_BYTES = 65536,
   parameter int MIN_BLOCK    = 16,
   parameter int MAX_BLOCK    = 4096,
   parameter int SIZE_CLASSES = 9
) (
   input logic    clock,
   input logic    reset,
   sca_req_if.sink   req_if,
   sca_rsp_if.source rsp_if,
   sca_csr_if.sink   csr_if
);
   import sca_pkg::*;

   localparam int HDR_DEPTH = BUFFER_BYTES / MIN_BLOCK;
   localparam int ADDR_W    = $clog2(HDR_DEPTH);
   localparam int LOG_MIN   = $clog2(MIN_BLOCK);
   localparam int CLS_W     = $clog2(SIZE_CLASSES);
   localparam int ALU_W     = 18;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_PREP    = 9'b000000010,
      S_CLASS   = 9'b000000100,
      S_SELECT  = 9'b000001000,
      S_POP     = 9'b000010000,
      S_BUMP    = 9'b000100000,
      S_FREE_RD = 9'b001000000,
      S_FREE_WR = 9'b010000000,
      S_REPLY   = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic                  op_ff, op_in;
   logic [SIZE_W-1:0]     size_ff, size_in;
   logic [OFFSET_W-1:0]   offset_ff, offset_in;
   logic [ALU_W-1:0]      alu_ff, alu_in;
   logic [CLS_W-1:0]      cls_ff, cls_in;
   logic [ADDR_W-1:0]     slot_ff, slot_in;
   logic [POOL_W-1:0]     cursor_ff, cursor_in;
   logic [POOL_W-1:0]     pool_ff, pool_in;
   link_type              heads_ff [SIZE_CLASSES];
   link_type              heads_in [SIZE_CLASSES];
   logic [OFFSET_W-1:0]   grant_ff, grant_in;
   status_type            status_ff, status_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OFFSET_W-1:0]   rsp_grant_ff, rsp_grant_in;
   status_type            rsp_status_ff, rsp_status_in;

   logic                  req_fire;
   logic                  out_free;
   logic [ALU_W-1:0]      alu_a, alu_b, alu_res;
   logic                  alu_sub;
   logic [4:0]            sum_width;
   logic [4:0]            cls_full;
   logic [ALU_W-1:0]      blk_size;
   logic [ALU_W-1:0]      eff_pool;
   link_type              head;
   logic [31:0]           free_idx, pop_idx, bump_idx, slot_word, pop_start;
   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [LINK_W-1:0]     wr_data, rd_data;

   sca_ram #(
      .WIDTH(LINK_W),
      .DEPTH(HDR_DEPTH)
   ) u_hdr_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_fire      = req_if.valid && req_if.ready;
   assign req_if.ready  = (state_ff == S_IDLE) && !reset;
   assign csr_if.ready  = !reset;
   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.granted_offset = rsp_grant_ff;
   assign rsp_if.status = rsp_status_ff;

   assign alu_res = alu_a + (alu_sub ? ~alu_b : alu_b) + ALU_W'(alu_sub);

   always_comb begin
      sum_width = '0;
      for (int i = 0; i < POOL_W; i++) begin
         if (alu_ff[i]) begin
            sum_width = 5'(i + 1);
         end
      end
   end

   assign cls_full  = (sum_width > 5'(LOG_MIN)) ? sum_width - 5'(LOG_MIN) : 5'd0;
   assign blk_size  = ALU_W'(1) << (5'(LOG_MIN) + 5'(cls_ff));
   assign eff_pool  = (32'(pool_ff) > BUFFER_BYTES) ? ALU_W'(BUFFER_BYTES)
                                                    : ALU_W'(pool_ff);
   assign head      = heads_ff[cls_ff];
   assign free_idx  = 32'(alu_ff[OFFSET_W-1:0]) >> LOG_MIN;
   assign pop_idx   = 32'(head.index);
   assign bump_idx  = 32'(cursor_ff) >> LOG_MIN;
   assign slot_word = 32'(slot_ff);
   assign pop_start = slot_word << LOG_MIN;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      offset_in     = offset_ff;
      alu_in        = alu_ff;
      cls_in        = cls_ff;
      slot_in       = slot_ff;
      cursor_in     = cursor_ff;
      pool_in       = pool_ff;
      heads_in      = heads_ff;
      grant_in      = grant_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_grant_in  = rsp_grant_ff;
      rsp_status_in = rsp_status_ff;
      alu_a         = ALU_W'(cursor_ff);
      alu_b         = blk_size;
      alu_sub       = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      wr_data       = LINK_W'(cls_ff);
      rd_en         = 1'b0;
      rd_addr       = free_idx[ADDR_W-1:0];

      if (csr_if.valid) begin
         pool_in = csr_if.pool_bytes;
      end
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_if.operation;
               size_in   = req_if.request_size;
               offset_in = req_if.data_offset;
               state_in  = S_PREP;
            end
         end
         S_PREP: begin
            grant_in  = '0;
            status_in = ST_OK;
            alu_b     = ALU_W'(HEADER_BYTES);
            if (op_ff == OP_ALLOC) begin
               alu_a = ALU_W'(size_ff);
            end else begin
               alu_a   = ALU_W'(offset_ff);
               alu_sub = 1'b1;
            end
            alu_in = alu_res;
            if (op_ff == OP_ALLOC && size_ff == '0) begin
               status_in = ST_ZERO;
               state_in  = S_REPLY;
            end else if (op_ff == OP_FREE && offset_ff == '0) begin
               status_in = ST_NULL;
               state_in  = S_REPLY;
            end else begin
               state_in = S_CLASS;
            end
         end
         S_CLASS: begin
            if (op_ff == OP_FREE) begin
               rd_en    = 1'b1;
               rd_addr  = free_idx[ADDR_W-1:0];
               slot_in  = free_idx[ADDR_W-1:0];
               state_in = S_FREE_RD;
            end else if (32'(alu_ff) >= MAX_BLOCK || 32'(cls_full) >= SIZE_CLASSES) begin
               status_in = ST_LARGE;
               state_in  = S_REPLY;
            end else begin
               cls_in   = cls_full[CLS_W-1:0];
               state_in = S_SELECT;
            end
         end
         S_SELECT: begin
            if (head.valid) begin
               rd_en    = 1'b1;
               rd_addr  = pop_idx[ADDR_W-1:0];
               slot_in  = pop_idx[ADDR_W-1:0];
               state_in = S_POP;
            end else begin
               alu_a    = ALU_W'(cursor_ff);
               alu_b    = blk_size;
               alu_in   = alu_res;
               state_in = S_BUMP;
            end
         end
         S_POP: begin
            heads_in[cls_ff] = link_type'(rd_data);
            wr_en            = 1'b1;
            wr_addr          = slot_ff;
            wr_data          = LINK_W'(cls_ff);
            grant_in         = pop_start[OFFSET_W-1:0] | HEADER_BYTES;
            state_in         = S_REPLY;
         end
         S_BUMP: begin
            if (alu_ff > eff_pool) begin
               status_in = ST_NOSPACE;
            end else begin
               cursor_in = alu_ff[POOL_W-1:0];
               wr_en     = 1'b1;
               wr_addr   = bump_idx[ADDR_W-1:0];
               wr_data   = LINK_W'(cls_ff);
               grant_in  = cursor_ff[OFFSET_W-1:0] | HEADER_BYTES;
            end
            state_in = S_REPLY;
         end
         S_FREE_RD: begin
            if (32'(rd_data) >= SIZE_CLASSES) begin
               state_in = S_REPLY;
            end else begin
               cls_in   = rd_data[CLS_W-1:0];
               state_in = S_FREE_WR;
            end
         end
         S_FREE_WR: begin
            wr_en            = 1'b1;
            wr_addr          = slot_ff;
            wr_data          = head;
            heads_in[cls_ff] = '{valid: 1'b1, index: slot_word[INDEX_W-1:0]};
            state_in         = S_REPLY;
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_grant_in  = grant_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cursor_ff    <= '0;
         pool_ff      <= POOL_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SIZE_CLASSES; i++) begin
            heads_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         pool_ff      <= pool_in;
         rsp_valid_ff <= rsp_valid_in;
         heads_ff     <= heads_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      offset_ff     <= offset_in;
      alu_ff        <= alu_in;
      cls_ff        <= cls_in;
      slot_ff       <= slot_in;
      grant_ff      <= grant_in;
      status_ff     <= status_in;
      rsp_grant_ff  <= rsp_grant_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_PREP)
      else $error("accepted request did not start the sequencer");

   a_refusal_no_grant: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_grant_ff == '0)
      else $error("refused request carries a granted offset");

   a_header_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_POP || state_ff == S_BUMP || state_ff == S_FREE_WR)
      else $error("header write outside a commit step");

   a_cursor_grows: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> cursor_ff >= $past(cursor_ff))
      else $error("bump cursor moved backward");

endmodule

### rtl/core/sca_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sca_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
